### sv/signed_decimal_add_sub_macros.svh
// Assertion helpers, clocked on clk, disabled during reset.
`ifndef SIGNED_DECIMAL_ADD_SUB_MACROS_SVH
`define SIGNED_DECIMAL_ADD_SUB_MACROS_SVH

`define SDAS_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("sdas assertion failed");

`define SDAS_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("sdas assertion failed");

`endif

### sv/sdas_pkg.sv
`default_nettype none
package sdas_pkg;

  localparam int MAX_DIGITS = 32;
  localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W      = $clog2(MAX_DIGITS);
  localparam int DIGIT_W    = 4;
  localparam int RADIX      = 10;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    digit_t a_digit;
    digit_t b_digit;
    logic   a_negative;
    logic   b_negative;
    logic   opcode;
    logic   last_digit;
  } in_item_t;

  typedef struct packed {
    digit_t result_digit;
    logic   result_negative;
    logic   digits_dropped;
    logic   last_result;
  } out_item_t;

  typedef struct packed {
    logic subtract;
    logic swap;
    logic carry;
  } alu_ctrl_t;

  typedef struct packed {
    digit_t digit;
    logic   carry;
    logic   a_gt;
    logic   a_lt;
  } alu_stat_t;

endpackage
`default_nettype wire

### sv/sdas_digit_store.sv
`default_nettype none
module sdas_digit_store (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [sdas_pkg::IDX_W-1:0] wr_addr,
  input  wire sdas_pkg::digit_t           wr_a,
  input  wire sdas_pkg::digit_t           wr_b,
  input  wire logic [sdas_pkg::IDX_W-1:0] rd_addr,
  output sdas_pkg::digit_t                rd_a,
  output sdas_pkg::digit_t                rd_b
);

  logic [2*sdas_pkg::DIGIT_W-1:0] mem [sdas_pkg::MAX_DIGITS];
  logic [2*sdas_pkg::DIGIT_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_a, wr_b};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_a = rd_data_r[2*sdas_pkg::DIGIT_W-1:sdas_pkg::DIGIT_W];
  assign rd_b = rd_data_r[sdas_pkg::DIGIT_W-1:0];

endmodule
`default_nettype wire

### sv/sdas_digit_alu.sv
`default_nettype none
module sdas_digit_alu (
  input  wire sdas_pkg::digit_t    a,
  input  wire sdas_pkg::digit_t    b,
  input  wire sdas_pkg::alu_ctrl_t ctrl,
  output sdas_pkg::alu_stat_t      stat
);

  localparam logic [sdas_pkg::DIGIT_W:0] RADIX_V = (sdas_pkg::DIGIT_W + 1)'(sdas_pkg::RADIX);

  logic [sdas_pkg::DIGIT_W:0] x;
  logic [sdas_pkg::DIGIT_W:0] y;
  logic [sdas_pkg::DIGIT_W:0] sub_v;
  logic [sdas_pkg::DIGIT_W:0] sum_v;
  logic [sdas_pkg::DIGIT_W:0] res;

  always_comb begin
    x = ctrl.swap ? {1'b0, b} : {1'b0, a};
    y = ctrl.swap ? {1'b0, a} : {1'b0, b};
    sub_v = y + {{sdas_pkg::DIGIT_W{1'b0}}, ctrl.carry};
    sum_v = x + y + {{sdas_pkg::DIGIT_W{1'b0}}, ctrl.carry};
    if (ctrl.subtract) begin
      if (x >= sub_v) begin
        res        = x - sub_v;
        stat.carry = 1'b0;
      end else begin
        res        = x + RADIX_V - sub_v;
        stat.carry = 1'b1;
      end
    end else begin
      if (sum_v >= RADIX_V) begin
        res        = sum_v - RADIX_V;
        stat.carry = 1'b1;
      end else begin
        res        = sum_v;
        stat.carry = 1'b0;
      end
    end
    stat.digit = res[sdas_pkg::DIGIT_W-1:0];
    stat.a_gt  = (a > b);
    stat.a_lt  = (a < b);
  end

endmodule
`default_nettype wire

### sv/signed_decimal_add_sub.sv
// Channel  | Ports                  | Transfer
// ---------+------------------------+------------------------------
// input    | start, busy, in_item   | start high while busy low
// result   | out_valid, out_item    | every cycle out_valid is high
//
// A digit pair that is not last is only stored and busy stays low. The
// last pair starts a compare (unlike signs only, stops at the first
// differing digit), then an add or subtract pass and a final carry
// result; one digit store with a separate write port and a registered
// read feeds one shared digit unit. rst_n is synchronous and clears
// control state only. Results go out one per strobe, no stalls.
`default_nettype none
`include "signed_decimal_add_sub_macros.svh"
module signed_decimal_add_sub (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire sdas_pkg::in_item_t  in_item,
  output logic                     out_valid,
  output sdas_pkg::out_item_t      out_item
);

  typedef enum logic [2:0] {
    IDLE, CMP_RD, CMP_EX, ADD_RD, ADD_EX, FINAL
  } state_t;

  localparam logic [sdas_pkg::COUNT_W-1:0] MAX_CNT = sdas_pkg::COUNT_W'(sdas_pkg::MAX_DIGITS);
  localparam sdas_pkg::digit_t NINE = sdas_pkg::DIGIT_W'(sdas_pkg::RADIX - 1);

  state_t                         state_r, state_nxt;
  logic [sdas_pkg::COUNT_W-1:0]   count_r, count_nxt;
  logic                           ovf_r, ovf_nxt;
  logic [sdas_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [sdas_pkg::IDX_W-1:0]     last_idx_r, last_idx_nxt;
  logic                           sub_r, sub_nxt;
  logic                           swap_r, swap_nxt;
  logic                           neg_r, neg_nxt;
  logic                           bneg_r, bneg_nxt;
  logic                           carry_r, carry_nxt;
  logic                           out_valid_r, out_valid_nxt;
  sdas_pkg::out_item_t            out_item_r, out_item_nxt;

  logic                           accept;
  logic                           wr_en;
  logic [sdas_pkg::COUNT_W-1:0]   n_cnt;
  logic                           b_eff;
  sdas_pkg::digit_t               a_sat, b_sat;
  sdas_pkg::digit_t               rd_a, rd_b;
  sdas_pkg::alu_ctrl_t            alu_ctrl;
  sdas_pkg::alu_stat_t            alu_stat;

  assign accept = start && (state_r == IDLE);
  assign wr_en  = accept && (count_r < MAX_CNT);
  assign a_sat  = (in_item.a_digit > NINE) ? NINE : in_item.a_digit;
  assign b_sat  = (in_item.b_digit > NINE) ? NINE : in_item.b_digit;
  assign n_cnt  = wr_en ? count_r + 1'b1 : count_r;
  assign b_eff  = in_item.b_negative ^ in_item.opcode;

  assign alu_ctrl.subtract = sub_r;
  assign alu_ctrl.swap     = swap_r;
  assign alu_ctrl.carry    = carry_r;

  sdas_digit_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[sdas_pkg::IDX_W-1:0]),
    .wr_a    (a_sat),
    .wr_b    (b_sat),
    .rd_addr (idx_r),
    .rd_a    (rd_a),
    .rd_b    (rd_b)
  );

  sdas_digit_alu u_alu (
    .a    (rd_a),
    .b    (rd_b),
    .ctrl (alu_ctrl),
    .stat (alu_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    sub_nxt       = sub_r;
    swap_nxt      = swap_r;
    neg_nxt       = neg_r;
    bneg_nxt      = bneg_r;
    carry_nxt     = carry_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    case (state_r)
      IDLE: begin
        if (accept) begin
          count_nxt = n_cnt;
          if (!wr_en) begin
            ovf_nxt = 1'b1;
          end
          if (in_item.last_digit) begin
            last_idx_nxt = sdas_pkg::IDX_W'(n_cnt - 1'b1);
            sub_nxt      = (in_item.a_negative != b_eff);
            neg_nxt      = in_item.a_negative;
            bneg_nxt     = b_eff;
            swap_nxt     = 1'b0;
            carry_nxt    = 1'b0;
            if (in_item.a_negative != b_eff) begin
              idx_nxt   = sdas_pkg::IDX_W'(n_cnt - 1'b1);
              state_nxt = CMP_RD;
            end else begin
              idx_nxt   = '0;
              state_nxt = ADD_RD;
            end
          end
        end
      end
      CMP_RD: state_nxt = CMP_EX;
      CMP_EX: begin
        if (alu_stat.a_gt) begin
          idx_nxt   = '0;
          state_nxt = ADD_RD;
        end else if (alu_stat.a_lt) begin
          swap_nxt  = 1'b1;
          neg_nxt   = bneg_r;
          idx_nxt   = '0;
          state_nxt = ADD_RD;
        end else if (idx_r == '0) begin
          neg_nxt   = 1'b0;
          state_nxt = ADD_RD;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = CMP_RD;
        end
      end
      ADD_RD: state_nxt = ADD_EX;
      ADD_EX: begin
        out_valid_nxt                = 1'b1;
        out_item_nxt.result_digit    = alu_stat.digit;
        out_item_nxt.result_negative = neg_r;
        out_item_nxt.digits_dropped  = ovf_r;
        out_item_nxt.last_result     = 1'b0;
        carry_nxt                    = alu_stat.carry;
        if (idx_r == last_idx_r) begin
          state_nxt = FINAL;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ADD_RD;
        end
      end
      FINAL: begin
        out_valid_nxt                = 1'b1;
        out_item_nxt.result_digit    = sub_r ? '0 : {{(sdas_pkg::DIGIT_W-1){1'b0}}, carry_r};
        out_item_nxt.result_negative = neg_r;
        out_item_nxt.digits_dropped  = ovf_r;
        out_item_nxt.last_result     = 1'b1;
        count_nxt                    = '0;
        ovf_nxt                      = 1'b0;
        state_nxt                    = IDLE;
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    sub_r      <= sub_nxt;
    swap_r     <= swap_nxt;
    neg_r      <= neg_nxt;
    bneg_r     <= bneg_nxt;
    carry_r    <= carry_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `SDAS_ASSERT_SAME(a_last_idle, out_valid && out_item.last_result, !busy && count_r == '0)
  `SDAS_ASSERT_SAME(a_count_max, 1'b1, count_r <= MAX_CNT)
  `SDAS_ASSERT_SAME(a_digit_dec, out_valid, out_item.result_digit <= NINE)
  `SDAS_ASSERT_NEXT(a_final_next, state_r == FINAL, out_valid && out_item.last_result)

endmodule
`default_nettype wire

### tb/tb_signed_decimal_add_sub.sv
`default_nettype none
module tb_signed_decimal_add_sub;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_SUB = 1'b1;
  localparam logic POS = 1'b0;
  localparam logic NEG = 1'b1;
  localparam int unsigned DRAIN_CYCLES = 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sdas_pkg::in_item_t in_item = '0;
  logic out_valid;
  sdas_pkg::out_item_t out_item;

  // predictor state
  sdas_pkg::digit_t a_store [sdas_pkg::MAX_DIGITS];
  sdas_pkg::digit_t b_store [sdas_pkg::MAX_DIGITS];
  int unsigned stored_pairs = 0;
  logic pairs_dropped = 1'b0;
  sdas_pkg::out_item_t expected_digits [$];

  int unsigned error_count = 0;
  int unsigned items_sent = 0;
  int unsigned digits_seen = 0;
  bit steady_sender = 1'b0;

  signed_decimal_add_sub u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at result %0d: %s got %0d expected %0d",
             digits_seen, what, got, want);
    error_count++;
  endtask

  // Stores one digit pair; on the last pair works out the whole signed result.
  function automatic void compute_decimal_result(input sdas_pkg::in_item_t item);
    sdas_pkg::digit_t ad;
    sdas_pkg::digit_t bd;
    logic b_neg;
    logic sign;
    logic subtract;
    logic swap;
    int rel;
    int unsigned carry;
    int unsigned x;
    int unsigned y;
    int unsigned d;
    sdas_pkg::out_item_t r;
    ad = (item.a_digit > 9) ? sdas_pkg::digit_t'(9) : item.a_digit;
    bd = (item.b_digit > 9) ? sdas_pkg::digit_t'(9) : item.b_digit;
    if (stored_pairs < sdas_pkg::MAX_DIGITS) begin
      a_store[sdas_pkg::IDX_W'(stored_pairs)] = ad;
      b_store[sdas_pkg::IDX_W'(stored_pairs)] = bd;
      stored_pairs++;
    end else begin
      pairs_dropped = 1'b1;
    end
    if (!item.last_digit) return;

    b_neg = item.b_negative ^ (item.opcode == OP_SUB);
    subtract = (item.a_negative != b_neg);
    sign = item.a_negative;
    swap = 1'b0;
    if (subtract) begin
      rel = 0;
      for (int i = int'(stored_pairs) - 1; i >= 0 && rel == 0; i--) begin
        if (a_store[sdas_pkg::IDX_W'(i)] > b_store[sdas_pkg::IDX_W'(i)]) rel = 1;
        else if (a_store[sdas_pkg::IDX_W'(i)] < b_store[sdas_pkg::IDX_W'(i)]) rel = -1;
      end
      if (rel == 0) begin
        sign = POS;
      end else if (rel < 0) begin
        swap = 1'b1;
        sign = b_neg;
      end
    end

    carry = 0;
    for (int unsigned i = 0; i < stored_pairs; i++) begin
      x = swap ? 32'(b_store[sdas_pkg::IDX_W'(i)]) : 32'(a_store[sdas_pkg::IDX_W'(i)]);
      y = swap ? 32'(a_store[sdas_pkg::IDX_W'(i)]) : 32'(b_store[sdas_pkg::IDX_W'(i)]);
      if (subtract) begin
        if (x >= y + carry) begin
          d = x - (y + carry);
          carry = 0;
        end else begin
          d = x + sdas_pkg::RADIX - (y + carry);
          carry = 1;
        end
      end else begin
        d = x + y + carry;
        carry = (d >= sdas_pkg::RADIX) ? 1 : 0;
        if (carry != 0) d -= sdas_pkg::RADIX;
      end
      r.result_digit = sdas_pkg::digit_t'(d);
      r.result_negative = sign;
      r.digits_dropped = pairs_dropped;
      r.last_result = 1'b0;
      expected_digits.push_back(r);
    end
    r.result_digit = subtract ? sdas_pkg::digit_t'(0) : sdas_pkg::digit_t'(carry);
    r.result_negative = sign;
    r.digits_dropped = pairs_dropped;
    r.last_result = 1'b1;
    expected_digits.push_back(r);
    stored_pairs = 0;
    pairs_dropped = 1'b0;
  endfunction

  always @(posedge clk) begin
    sdas_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      digits_seen++;
      if (expected_digits.size() == 0) begin
        report_mismatch("unexpected result, digit", 32'(out_item.result_digit), 0);
      end else begin
        want = expected_digits.pop_front();
        if (out_item.result_digit !== want.result_digit)
          report_mismatch("result_digit", 32'(out_item.result_digit),
                          32'(want.result_digit));
        if (out_item.result_negative !== want.result_negative)
          report_mismatch("result_negative", 32'(out_item.result_negative),
                          32'(want.result_negative));
        if (out_item.digits_dropped !== want.digits_dropped)
          report_mismatch("digits_dropped", 32'(out_item.digits_dropped),
                          32'(want.digits_dropped));
        if (out_item.last_result !== want.last_result)
          report_mismatch("last_result", 32'(out_item.last_result),
                          32'(want.last_result));
      end
    end
  end

  function automatic sdas_pkg::in_item_t make_item(input sdas_pkg::digit_t a,
                                                   input sdas_pkg::digit_t b,
                                                   input logic a_neg, input logic b_neg,
                                                   input logic op, input logic last);
    sdas_pkg::in_item_t item;
    item.a_digit = a;
    item.b_digit = b;
    item.a_negative = a_neg;
    item.b_negative = b_neg;
    item.opcode = op;
    item.last_digit = last;
    return item;
  endfunction

  function automatic sdas_pkg::digit_t rand_digit();
    if ($urandom_range(99) < 8) return sdas_pkg::digit_t'($urandom_range(15, 10));
    return sdas_pkg::digit_t'($urandom_range(9, 0));
  endfunction

  // One transfer on the input channel, then an optional random gap.
  task automatic send_item(input sdas_pkg::in_item_t item);
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    compute_decimal_result(item);
    items_sent++;
    if (!steady_sender && $urandom_range(99) < 22) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 22);
    end
  endtask

  // B is either a copy of A, a copy with one digit changed, or independent.
  task automatic send_number(input int unsigned len, input logic a_neg, input logic b_neg,
                             input logic op);
    int unsigned mode;
    int unsigned tweak;
    sdas_pkg::digit_t a;
    sdas_pkg::digit_t b;
    logic last;
    mode = $urandom_range(3);
    tweak = $urandom_range(len - 1);
    for (int unsigned i = 0; i < len; i++) begin
      a = rand_digit();
      b = (mode == 0 || (mode == 1 && i != tweak)) ? a : rand_digit();
      last = (i == len - 1);
      if (last) send_item(make_item(a, b, a_neg, b_neg, op, 1'b1));
      else send_item(make_item(a, b, 1'($urandom_range(1)), 1'($urandom_range(1)),
                               1'($urandom_range(1)), 1'b0));
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes();
    send_item(make_item(4'd9, 4'd9, POS, POS, OP_ADD, 1'b1));
    send_item(make_item(4'd0, 4'd0, NEG, NEG, OP_ADD, 1'b1));
    send_item(make_item(4'd15, 4'd15, POS, POS, OP_SUB, 1'b1));
    send_item(make_item(4'd0, 4'd15, NEG, POS, OP_ADD, 1'b1));
    send_item(make_item(4'd9, 4'd1, POS, POS, OP_ADD, 1'b0));
    send_item(make_item(4'd9, 4'd0, POS, POS, OP_ADD, 1'b0));
    send_item(make_item(4'd9, 4'd0, POS, POS, OP_ADD, 1'b1));
  endtask

  task automatic test_sign_op_combos();
    for (int k = 0; k < 8; k++) begin
      send_item(make_item(4'd7, 4'd8, k[2], k[1], k[0], 1'b0));
      send_item(make_item(4'd3, 4'd5, k[2], k[1], k[0], 1'b1));
    end
  endtask

  task automatic test_store_full();
    send_number(sdas_pkg::MAX_DIGITS + 1, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
    send_number(sdas_pkg::MAX_DIGITS + 3, 1'($urandom_range(1)), 1'($urandom_range(1)),
                1'($urandom_range(1)));
  endtask

  task automatic test_random_traffic(input int unsigned item_goal);
    int unsigned target;
    int unsigned len;
    target = items_sent + item_goal;
    while (items_sent < target) begin
      len = ($urandom_range(99) < 4) ? sdas_pkg::MAX_DIGITS : $urandom_range(8, 1);
      send_number(len, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
    end
  endtask

  task automatic test_back_to_back();
    steady_sender = 1'b1;
    test_random_traffic(40);
    steady_sender = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 5; k++) begin
      send_number($urandom_range(6, 1), 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      wait_for_results();
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_sign_op_combos();
    test_store_full();
    test_random_traffic(60);
    test_back_to_back();
    test_drain_pause();
    test_random_traffic(60);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_digits.size() == 0) begin
      $display("signed_decimal_add_sub test passed");
    end else begin
      $display("signed_decimal_add_sub test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("signed_decimal_add_sub test failed");
    $finish;
  end

endmodule
`default_nettype wire

### files.f
+incdir+sv
sv/sdas_pkg.sv
sv/sdas_digit_store.sv
sv/sdas_digit_alu.sv
sv/signed_decimal_add_sub.sv
tb/tb_signed_decimal_add_sub.sv
